// ===== design/tfr_pkg.sv =====
package tfr_pkg;

  localparam logic [7:0] HDR_FIRST   = 8'hAA;
  localparam logic [7:0] HDR_SECOND  = 8'hAF;
  localparam logic [7:0] CODE_BOUND  = 8'hF1;
  localparam logic [7:0] HDR_SUM     = 8'h59;
  localparam logic [7:0] LIMIT_RESET = 8'd50;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_HDR2    = 3'd1,
    PH_CODE    = 3'd2,
    PH_LEN     = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_CHECK   = 3'd5
  } phase_t;

  typedef struct packed {
    logic       frame_end;
    logic [7:0] function_code;
    logic [7:0] frame_length;
    logic [7:0] byte_index;
    logic [7:0] payload_byte;
    logic       checksum_ok;
  } result_t;

endpackage

// ===== design/telemetry_frame_receiver_unit.sv =====
// Telemetry frame receiver. Each accepted request carries one received serial
// byte; the unit hunts for the header 0xAA 0xAF, checks the function code
// (below 0xF1) and the length (below length_limit), then emits one result per
// payload byte with its index and a final result carrying the received
// checksum byte and a pass flag. Bad header, code or length bytes send the
// parser back to hunting, and a zero length goes straight to the checksum.
// The unit takes one byte every cycle while in_stall is low; a result is
// written into the output register, or into the skid register while the
// output register is held, when its byte is accepted. A two-entry output
// stage (result register plus skid register) lets input flow continue while
// a result waits, so in_stall rises only when both entries are occupied.
// length_limit resets to 50 and is written through the cfg channel, which is
// always ready and must only be used while the unit is idle.
module telemetry_frame_receiver_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       frame_end,
  output logic [7:0] function_code,
  output logic [7:0] frame_length,
  output logic [7:0] byte_index,
  output logic [7:0] payload_byte,
  output logic       checksum_ok,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);
  import tfr_pkg::*;

  logic [7:0] length_limit;
  logic       fire;
  logic       res_valid;
  result_t    res;
  result_t    out_data;

  // The configuration register accepts a write on every cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      length_limit <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      length_limit <= cfg_data;
    end
  end

  // A byte is taken whenever the skid register is free.
  assign fire = in_valid && !in_stall;

  tfr_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .rx_byte      (rx_byte),
    .length_limit (length_limit),
    .res_valid    (res_valid),
    .res          (res)
  );

  tfr_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (fire && res_valid),
    .push_data (res),
    .full      (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign frame_end     = out_data.frame_end;
  assign function_code = out_data.function_code;
  assign frame_length  = out_data.frame_length;
  assign byte_index    = out_data.byte_index;
  assign payload_byte  = out_data.payload_byte;
  assign checksum_ok   = out_data.checksum_ok;

  // The skid register only fills behind an occupied result register.
  a_skid_behind_main: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("skid entry held while result register empty");

  // Payload results always lie inside the announced length.
  a_index_in_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !frame_end) |-> (byte_index < frame_length))
    else $error("payload index outside frame length");

  // Only a frame end can report a checksum pass, and it carries index zero.
  a_end_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && checksum_ok) |-> (frame_end && byte_index == 8'd0))
    else $error("checksum pass flag on a payload result");

  // A full output stage that is stalled holds off the input side in the next cycle too.
  a_full_blocks: assert property (@(posedge clk) disable iff (rst)
    (in_stall && out_stall) |=> in_stall)
    else $error("output stage drained while stalled");

endmodule

// ===== design/tfr_parser.sv =====
module tfr_parser (
  input  logic            clk,
  input  logic            rst,
  input  logic            fire,
  input  logic [7:0]      rx_byte,
  input  logic [7:0]      length_limit,
  output logic            res_valid,
  output tfr_pkg::result_t res
);
  import tfr_pkg::*;

  phase_t     phase, phase_next;
  logic [7:0] code_reg, code_reg_next;
  logic [7:0] length_reg, length_reg_next;
  logic [7:0] count_reg, count_reg_next;
  logic [7:0] running_sum, running_sum_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HUNT;
      code_reg    <= '0;
      length_reg  <= '0;
      count_reg   <= '0;
      running_sum <= '0;
    end else if (fire) begin
      phase       <= phase_next;
      code_reg    <= code_reg_next;
      length_reg  <= length_reg_next;
      count_reg   <= count_reg_next;
      running_sum <= running_sum_next;
    end
  end

  always_comb begin
    phase_next       = PH_HUNT;
    code_reg_next    = code_reg;
    length_reg_next  = length_reg;
    count_reg_next   = count_reg;
    running_sum_next = running_sum;
    res_valid        = 1'b0;
    res.frame_end     = 1'b0;
    res.function_code = code_reg;
    res.frame_length  = length_reg;
    res.byte_index    = count_reg;
    res.payload_byte  = rx_byte;
    res.checksum_ok   = 1'b0;
    unique case (phase)
      PH_HDR2: begin
        if (rx_byte == HDR_SECOND) begin
          running_sum_next = HDR_SUM;
          phase_next       = PH_CODE;
        end
      end
      PH_CODE: begin
        if (rx_byte < CODE_BOUND) begin
          code_reg_next    = rx_byte;
          running_sum_next = running_sum + rx_byte;
          phase_next       = PH_LEN;
        end
      end
      PH_LEN: begin
        if (rx_byte < length_limit) begin
          length_reg_next  = rx_byte;
          count_reg_next   = '0;
          running_sum_next = running_sum + rx_byte;
          phase_next       = (rx_byte == 8'd0) ? PH_CHECK : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        res_valid        = 1'b1;
        running_sum_next = running_sum + rx_byte;
        count_reg_next   = count_reg + 8'd1;
        phase_next       = (count_reg_next == length_reg) ? PH_CHECK : PH_PAYLOAD;
      end
      PH_CHECK: begin
        res_valid       = 1'b1;
        res.frame_end   = 1'b1;
        res.byte_index  = '0;
        res.checksum_ok = (running_sum == rx_byte);
      end
      default: begin
        // Hunting, and the unused phase codes, look for the first header byte.
        phase_next = (rx_byte == HDR_FIRST) ? PH_HDR2 : PH_HUNT;
      end
    endcase
  end

endmodule

// ===== design/tfr_out_stage.sv =====
module tfr_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  tfr_pkg::result_t push_data,
  output logic             full,
  output logic             out_valid,
  input  logic             out_stall,
  output tfr_pkg::result_t out_data
);
  import tfr_pkg::*;

  logic    skid_valid;
  result_t skid_data;
  logic    load_main;

  assign load_main = !out_valid || !out_stall;
  assign full      = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (load_main) begin
      out_valid  <= skid_valid || push;
      skid_valid <= skid_valid && push;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_main) begin
      out_data  <= skid_valid ? skid_data : push_data;
      skid_data <= push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

// ===== tb/tb_telemetry_frame_receiver_unit.sv =====
// Self-checking bench for the telemetry frame receiver. A sequencer in the
// main initial block fills a byte queue. A clocked driver presents those
// bytes as input requests, and a clocked monitor checks every output request
// against a running model of the frame parser. The run goes through several
// length limits. The limit is rewritten only while the unit is drained.
module tb_telemetry_frame_receiver_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import tfr_pkg::*;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] rx_byte = 8'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       frame_end;
  logic [7:0] function_code;
  logic [7:0] frame_length;
  logic [7:0] byte_index;
  logic [7:0] payload_byte;
  logic       checksum_ok;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data = 8'd0;

  telemetry_frame_receiver_unit dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .frame_end     (frame_end),
    .function_code (function_code),
    .frame_length  (frame_length),
    .byte_index    (byte_index),
    .payload_byte  (payload_byte),
    .checksum_ok   (checksum_ok),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  // A 2 ns clock period. The first rising edge comes at 1 ns.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // These are the bytes that wait to be sent and the results that the parser
  // model expects. The counters let the sequencer see when the unit has
  // drained.
  logic [7:0] rx_stream[$];
  result_t    expected_results[$];
  int         bytes_queued = 0;
  int         bytes_accepted = 0;
  int         mismatch_count = 0;
  int         payload_seen = 0;
  int         frame_ends_seen = 0;
  int         checksums_good = 0;

  // These knobs control idling. The sequencer changes them between phases.
  // The quiet flag turns off every burst for the last part of the run.
  int         send_idle_pct = 0;
  int         stall_pct = 0;
  bit         quiet = 1'b0;
  int         send_gap = 0;
  int         stall_left = 0;
  bit         in_took = 1'b0;

  // This is the state of the parser model. It is our own copy of the
  // length limit, plus the frame that is being assembled.
  logic [7:0] len_limit = LIMIT_RESET;
  phase_t     prs_phase = PH_HUNT;
  logic [7:0] cur_code = 8'd0;
  logic [7:0] cur_len = 8'd0;
  logic [7:0] seen_count = 8'd0;
  logic [7:0] csum = 8'd0;

  // This task advances the parser model by one received byte. A payload
  // byte or a checksum byte leaves one expected result behind.
  task automatic parse_byte(input logic [7:0] b);
    result_t r;
    case (prs_phase)
      PH_HDR2: begin
        // A wrong second header byte goes back to hunting. That same byte
        // is not taken again as a new first header byte.
        if (b == HDR_SECOND) begin
          csum = HDR_SUM;
          prs_phase = PH_CODE;
        end else begin
          prs_phase = PH_HUNT;
        end
      end
      PH_CODE: begin
        if (b < CODE_BOUND) begin
          cur_code = b;
          csum = csum + b;
          prs_phase = PH_LEN;
        end else begin
          prs_phase = PH_HUNT;
        end
      end
      PH_LEN: begin
        // A length of zero skips the payload and goes straight to the
        // checksum.
        if (b < len_limit) begin
          cur_len = b;
          seen_count = 8'd0;
          csum = csum + b;
          prs_phase = (b == 8'd0) ? PH_CHECK : PH_PAYLOAD;
        end else begin
          prs_phase = PH_HUNT;
        end
      end
      PH_PAYLOAD: begin
        r = '{frame_end: 1'b0, function_code: cur_code, frame_length: cur_len,
              byte_index: seen_count, payload_byte: b, checksum_ok: 1'b0};
        expected_results.push_back(r);
        csum = csum + b;
        seen_count = seen_count + 8'd1;
        if (seen_count == cur_len) prs_phase = PH_CHECK;
      end
      PH_CHECK: begin
        r = '{frame_end: 1'b1, function_code: cur_code, frame_length: cur_len,
              byte_index: 8'd0, payload_byte: b, checksum_ok: (csum == b)};
        expected_results.push_back(r);
        prs_phase = PH_HUNT;
      end
      default: begin
        prs_phase = (b == HDR_FIRST) ? PH_HDR2 : PH_HUNT;
      end
    endcase
  endtask

  // The monitor runs at the rising edge. It records every input request
  // that is taken, checks every output request that is taken, and feeds the
  // accepted byte to the parser model. A result is registered in the unit
  // before it can come out, so the check comes before the model update.
  always @(posedge clk) begin : monitor
    result_t seen;
    result_t want;
    if (rst) begin
      in_took = 1'b0;
    end else begin
      in_took = in_valid && !in_stall;
      if (out_valid && !out_stall) begin
        seen = '{frame_end: frame_end, function_code: function_code,
                 frame_length: frame_length, byte_index: byte_index,
                 payload_byte: payload_byte, checksum_ok: checksum_ok};
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("[%0t] unexpected: end=%0b code=%h len=%0d idx=%0d byte=%h ok=%0b",
                     $realtime, frame_end, function_code, frame_length, byte_index,
                     payload_byte, checksum_ok);
        end else begin
          want = expected_results.pop_front();
          if (seen !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("[%0t] mismatch: exp end=%0b code=%h len=%0d idx=%0d byte=%h ok=%0b",
                       $realtime, want.frame_end, want.function_code, want.frame_length,
                       want.byte_index, want.payload_byte, want.checksum_ok);
              $display("           got end=%0b code=%h len=%0d idx=%0d byte=%h ok=%0b",
                       seen.frame_end, seen.function_code, seen.frame_length,
                       seen.byte_index, seen.payload_byte, seen.checksum_ok);
            end
          end
          if (want.frame_end) begin
            frame_ends_seen++;
            if (want.checksum_ok) checksums_good++;
          end else begin
            payload_seen++;
          end
        end
      end
      if (in_took) begin
        bytes_accepted++;
        parse_byte(rx_byte);
      end
    end
  end

  // The driver runs at the falling edge. A request that is not taken holds
  // its byte. Otherwise the next byte comes from the queue, unless a random
  // idle burst is under way. The driver never looks at in_stall here. It
  // only uses the record of whether the last request was taken.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (rx_stream.size() == 0) begin
        in_valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < send_idle_pct) begin
        send_gap = $urandom_range(1, 6) - 1;
        in_valid <= 1'b0;
      end else begin
        rx_byte  <= rx_stream.pop_front();
        in_valid <= 1'b1;
      end
    end
  end

  // Backpressure on the result side comes in random bursts. It does not
  // depend on out_valid, so stalls fall on every phase of a frame.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
      stall_left = $urandom_range(1, 6) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic push_byte(input logic [7:0] b);
    rx_stream.push_back(b);
    bytes_queued++;
  endtask

  // This task queues one frame with random payload content. Sending fewer
  // payload bytes than the length cuts the frame short, and then no checksum
  // follows. A bad checksum has one bit flipped.
  task automatic push_frame(input logic [7:0] code, input logic [7:0] len,
                            input bit good_sum, input int sent);
    logic [7:0] sum;
    logic [7:0] b;
    sum = HDR_SUM + code + len;
    push_byte(HDR_FIRST);
    push_byte(HDR_SECOND);
    push_byte(code);
    push_byte(len);
    for (int i = 0; i < sent; i++) begin
      b = $urandom_range(0, 255);
      sum = sum + b;
      push_byte(b);
    end
    if (sent >= len) push_byte(good_sum ? sum : sum ^ (8'd1 << $urandom_range(0, 7)));
  endtask

  // This task queues random traffic. Most of it is well-formed frames, so
  // that the payload and checksum paths stay busy. The rest is line noise,
  // broken headers, codes out of range, lengths at or above the limit, and
  // frames cut short. Most lengths are short, and about one frame in twelve
  // draws a length from the full legal range.
  task automatic gen_traffic(input int n_items);
    int         stop_at;
    int         pick;
    int         len;
    int         top;
    logic [7:0] code;
    logic [7:0] b;
    stop_at = bytes_queued + n_items;
    while (bytes_queued < stop_at) begin
      pick = $urandom_range(0, 99);
      top  = (len_limit > 8'd13) ? 12 : len_limit - 1;
      len  = ($urandom_range(0, 11) == 0) ? $urandom_range(0, len_limit - 1)
                                           : $urandom_range(0, top);
      if ($urandom_range(0, 7) == 0)
        code = $urandom_range(0, 1) ? CODE_BOUND - 8'd1 : 8'd0;
      else
        code = $urandom_range(0, CODE_BOUND - 1);
      if (pick < 70) begin
        push_frame(code, len, $urandom_range(0, 4) != 0, len);
      end else if (pick < 78) begin
        repeat ($urandom_range(1, 4)) push_byte($urandom_range(0, 255));
      end else if (pick < 84) begin
        b = $urandom_range(0, 255);
        if (b == HDR_SECOND) b = HDR_FIRST;
        push_byte(HDR_FIRST);
        push_byte(b);
      end else if (pick < 89) begin
        push_byte(HDR_FIRST);
        push_byte(HDR_SECOND);
        push_byte($urandom_range(CODE_BOUND, 255));
      end else if (pick < 94) begin
        push_byte(HDR_FIRST);
        push_byte(HDR_SECOND);
        push_byte(code);
        push_byte($urandom_range(len_limit, 255));
      end else begin
        push_frame(code, len, 1'b1, $urandom_range(0, len));
      end
    end
  endtask

  // This task waits until every queued request has been taken and every
  // expected result has come out. A byte that makes no result may still be
  // inside the unit at that point, so the task then lets it settle before it returns.
  task automatic wait_drained();
    while (!(bytes_accepted == bytes_queued && expected_results.size() == 0))
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // This task writes the length limit while the unit is idle. Our own copy
  // of the limit follows the write at the edge where the write is taken.
  task automatic write_limit(input logic [7:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    len_limit = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // This is the sequencer. It runs one phase per length limit. The limit
  // starts at its reset value, goes to both extremes and to a random middle
  // value, and returns to the reset value for a last phase with no idling.
  initial begin : sequencer
    logic [7:0] mid_limit;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // This is the directed part, run with the reset limit of 50. It sends
    // an empty frame with a good checksum, and a frame with the largest
    // legal code and payload 0xFF but a bad checksum. Then comes a doubled
    // first header byte, where the real second header byte after it must
    // not restart a frame. Last come a code of 0xF1 and a length equal to
    // the limit.
    send_idle_pct = 10;
    stall_pct     = 10;
    push_frame(8'h00, 8'd0, 1'b1, 0);
    push_byte(HDR_FIRST);
    push_byte(HDR_SECOND);
    push_byte(CODE_BOUND - 8'd1);
    push_byte(8'd1);
    push_byte(8'hFF);
    push_byte(HDR_SUM + CODE_BOUND - 8'd1 + 8'd1 + 8'hFF + 8'd1);
    push_byte(HDR_FIRST);
    push_byte(HDR_FIRST);
    push_byte(HDR_SECOND);
    push_byte(8'h05);
    push_byte(8'h00);
    push_byte(HDR_SUM + 8'h05);
    push_byte(HDR_FIRST);
    push_byte(HDR_SECOND);
    push_byte(CODE_BOUND);
    push_byte(HDR_FIRST);
    push_byte(HDR_SECOND);
    push_byte(8'h10);
    push_byte(LIMIT_RESET);

    send_idle_pct = 20;
    stall_pct     = 20;
    gen_traffic(300);
    wait_drained();

    // With the smallest limit, only frames of length zero get through.
    write_limit(8'd1);
    send_idle_pct = 40;
    stall_pct     = 10;
    gen_traffic(150);
    wait_drained();

    // With the largest limit, one frame of the longest length goes first,
    // and it drives the byte index up to its top value.
    write_limit(8'd255);
    send_idle_pct = 10;
    stall_pct     = 40;
    push_frame($urandom_range(0, CODE_BOUND - 1), 8'd254, 1'b1, 254);
    gen_traffic(300);
    wait_drained();

    mid_limit = $urandom_range(2, 254);
    write_limit(mid_limit);
    send_idle_pct = 15;
    stall_pct     = 15;
    gen_traffic(300);
    wait_drained();

    // The last phase runs at full rate with no idling on either side.
    write_limit(LIMIT_RESET);
    quiet = 1'b1;
    gen_traffic(300);
    wait_drained();
    repeat (10) @(negedge clk);

    $display("Sent %0d bytes with length limits 50, 1, 255, %0d and 50, with random idling",
             bytes_accepted, mid_limit);
    $display("and stalls. Checked %0d payload results and %0d frame ends (%0d good checksums).",
             payload_seen, frame_ends_seen, checksums_good);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches found.", mismatch_count);
      $display("end of test: mismatches");
    end
    $finish;
  end

  // This is the watchdog. A correct run needs well under a tenth of this
  // time, even when every byte meets the longest gap and the longest stall.
  initial begin
    #2_000_000;
    $display("Timed out with %0d bytes still to send and %0d results still expected.",
             bytes_queued - bytes_accepted, expected_results.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
